// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the color ramp RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/cgr_pkg.sv =====
// Shared types and constants of the color gradient ramp.
// No dependencies; imported by every module of the ramp.
package cgr_pkg;

    localparam int N_STOPS  = 7;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int SEG_LAT  = 2;
    localparam int LERP_LAT = 7;
    localparam int TOTAL_LAT = SEG_LAT + LERP_LAT;

    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_STOP0 = 3'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color;

    typedef struct packed {
        logic [15:0] key;
        t_color      color;
    } t_stop;

    typedef struct packed {
        logic        direct;
        t_color      dcol;
        t_color      clo;
        t_color      chi;
        logic [15:0] t;
        logic [15:0] den;
    } t_seg;

    localparam t_color WHITE = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF};

endpackage

// ===== rtl/core/cgr_regs.sv =====
// Configuration register file with an APB-style write and read port.
// Depends on cgr_pkg for the stop layout and register codes.
module cgr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cgr_pkg::ADDR_W-1:0]  paddr,
    input  logic [cgr_pkg::DATA_W-1:0]  pwdata,
    output logic [cgr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [2:0]                  o_count,
    output cgr_pkg::t_stop              o_stop [cgr_pkg::N_STOPS]
);
    import cgr_pkg::*;

    logic [2:0] r_count;
    t_stop      r_stop [N_STOPS];
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < N_STOPS; i++) begin
                r_stop[i] <= '0;
            end
        end else if (wr) begin
            if (idx == REG_COUNT) begin
                r_count <= pwdata[2:0];
            end else begin
                for (int i = 0; i < N_STOPS; i++) begin
                    if (idx == REG_STOP0 + 3'(i)) begin
                        r_stop[i] <= pwdata[47:0];
                    end
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx == REG_COUNT) begin
            prdata = {61'd0, r_count};
        end else begin
            for (int i = 0; i < N_STOPS; i++) begin
                if (idx == REG_STOP0 + 3'(i)) begin
                    prdata = {16'd0, r_stop[i]};
                end
            end
        end
    end

    assign o_count = r_count;
    assign o_stop  = r_stop;

endmodule

// ===== rtl/core/cgr_seg.sv =====
// Segment search: finds the stop pair around a position in two register stages.
// Depends on cgr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cgr_seg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_position,
    input  logic [2:0]     i_count,
    input  cgr_pkg::t_stop i_stop [cgr_pkg::N_STOPS],
    output cgr_pkg::t_seg  o_seg
);
    import cgr_pkg::*;

    logic        r_s1_direct;
    t_color      r_s1_dcol;
    t_stop       r_s1_lo;
    t_stop       r_s1_hi;
    logic [15:0] r_s1_pos;
    t_seg        r_seg;

    logic        n_direct;
    t_color      n_dcol;
    t_stop       lo;
    t_stop       hi;
    t_stop       last;
    logic        seen;
    logic [N_STOPS-1:0] hit;
    logic [N_STOPS-1:0] first;

    always_comb begin
        hit   = '0;
        first = '0;
        seen  = 1'b0;
        lo    = i_stop[0];
        hi    = i_stop[0];
        last  = i_stop[0];
        for (int i = 1; i < N_STOPS; i++) begin
            hit[i]   = (3'(i) < i_count) && (i_position <= i_stop[i].key);
            first[i] = hit[i] && !seen;
            seen     = seen | hit[i];
        end
        for (int i = 1; i < N_STOPS; i++) begin
            if (first[i]) begin
                lo = i_stop[i-1];
                hi = i_stop[i];
            end
        end
        for (int i = 0; i < N_STOPS; i++) begin
            if (3'(i) == i_count - 3'd1) begin
                last = i_stop[i];
            end
        end

        n_direct = 1'b1;
        n_dcol   = last.color;
        if (i_count == 3'd0) begin
            n_dcol = WHITE;
        end else if (i_position <= i_stop[0].key) begin
            n_dcol = i_stop[0].color;
        end else if (seen) begin
            if (i_position == hi.key) begin
                n_dcol = hi.color;
            end else begin
                n_direct = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_direct  <= 1'b1;
            r_seg.direct <= 1'b1;
        end else begin
            r_s1_direct  <= n_direct;
            r_seg.direct <= r_s1_direct;
        end
        r_s1_dcol  <= n_dcol;
        r_s1_lo    <= lo;
        r_s1_hi    <= hi;
        r_s1_pos   <= i_position;
        r_seg.dcol <= r_s1_dcol;
        r_seg.clo  <= r_s1_lo.color;
        r_seg.chi  <= r_s1_hi.color;
        r_seg.t    <= r_s1_pos - r_s1_lo.key;
        r_seg.den  <= r_s1_hi.key - r_s1_lo.key;
    end

    assign o_seg = r_seg;

    `ASSERT_CLK(a_span_covers_offset, i_clk, i_rst_n,
        !r_seg.direct |-> (r_seg.den > r_seg.t),
        "Interpolation offset is not inside its segment.")
    `ASSERT_NEVER(a_offset_nonzero, i_clk, i_rst_n,
        !r_seg.direct && (r_seg.t == 16'd0),
        "Interpolation selected for a position that equals a stop key.")

endmodule

// ===== rtl/core/cgr_lerp.sv =====
// One color channel: multiply, rounded pipelined division and final offset.
// Imports cgr_pkg but uses none of its latency constants.
module cgr_lerp (
    input  logic        i_clk,
    input  logic        i_direct,
    input  logic [7:0]  i_dcol,
    input  logic [7:0]  i_clo,
    input  logic [7:0]  i_chi,
    input  logic [15:0] i_t,
    input  logic [15:0] i_den,
    output logic [7:0]  o_chan
);
    import cgr_pkg::*;

    localparam int DIV_ST = 4;

    logic [23:0] r_a_mag;
    logic        r_a_neg;
    logic [7:0]  r_a_clo;
    logic [15:0] r_a_den;
    logic        r_a_dir;
    logic [7:0]  r_a_dcol;

    logic [24:0] r_rem  [DIV_ST+1];
    logic [16:0] r_dv   [DIV_ST+1];
    logic [7:0]  r_q    [DIV_ST+1];
    logic [7:0]  r_clo  [DIV_ST+1];
    logic        r_neg  [DIV_ST+1];
    logic        r_dir  [DIV_ST+1];
    logic [7:0]  r_dcol [DIV_ST+1];
    logic [7:0]  r_res;

    logic [24:0] n_rem [DIV_ST];
    logic [7:0]  n_q   [DIV_ST];
    logic [7:0]  diff;
    logic        neg;
    logic [8:0]  sum;
    logic [7:0]  n_res;

    always_comb begin
        neg  = i_chi < i_clo;
        diff = neg ? (i_clo - i_chi) : (i_chi - i_clo);
    end

    always_comb begin
        logic [24:0] rem;
        logic [24:0] dsh;
        for (int s = 0; s < DIV_ST; s++) begin
            rem = r_rem[s];
            n_q[s] = r_q[s];
            for (int k = 0; k < 2; k++) begin
                dsh = 25'(r_dv[s]) << (7 - 2 * s - k);
                if (rem >= dsh) begin
                    rem = rem - dsh;
                    n_q[s][7 - 2 * s - k] = 1'b1;
                end
            end
            n_rem[s] = rem;
        end
    end

    always_comb begin
        logic [7:0] q;
        q     = r_q[DIV_ST];
        sum   = {1'b0, r_clo[DIV_ST]} + {1'b0, q};
        n_res = r_dcol[DIV_ST];
        if (!r_dir[DIV_ST]) begin
            if (r_neg[DIV_ST]) begin
                n_res = (q > r_clo[DIV_ST]) ? 8'd0 : (r_clo[DIV_ST] - q);
            end else begin
                n_res = sum[8] ? 8'hFF : sum[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= 24'(diff) * 24'(i_t);
        r_a_neg  <= neg;
        r_a_clo  <= i_clo;
        r_a_den  <= i_den;
        r_a_dir  <= i_direct;
        r_a_dcol <= i_dcol;

        r_rem[0]  <= {r_a_mag, 1'b0} + 25'(r_a_den);
        r_dv[0]   <= {r_a_den, 1'b0};
        r_q[0]    <= '0;
        r_clo[0]  <= r_a_clo;
        r_neg[0]  <= r_a_neg;
        r_dir[0]  <= r_a_dir;
        r_dcol[0] <= r_a_dcol;

        for (int s = 0; s < DIV_ST; s++) begin
            r_rem[s+1]  <= n_rem[s];
            r_dv[s+1]   <= r_dv[s];
            r_q[s+1]    <= n_q[s];
            r_clo[s+1]  <= r_clo[s];
            r_neg[s+1]  <= r_neg[s];
            r_dir[s+1]  <= r_dir[s];
            r_dcol[s+1] <= r_dcol[s];
        end

        r_res <= n_res;
    end

    assign o_chan = r_res;

endmodule

// ===== rtl/core/color_gradient_ramp.sv =====
// Piecewise-linear RGBA gradient: register file, segment search, four channels.
// Depends on cgr_pkg, cgr_regs, cgr_seg, cgr_lerp and assert_macros.svh.
//
//   Channel   Ports                                   Handshake
//   config    psel penable pwrite paddr pwdata        write when psel&penable&pwrite
//             prdata pready                           pready always high
//   request   start i_position busy                   taken when start && !busy
//   result    o_done o_red o_green o_blue o_alpha     one-cycle strobe on o_done
//
// A request is taken every cycle; busy stays low.
// Each result passes through two stages of segment search, one multiply
// stage, one numerator stage, four two-bit divider stages and one offset
// stage. Reset is synchronous and clears the registers to zero stops and
// empties the pipeline. Results cannot be held off.
`include "assert_macros.svh"

module color_gradient_ramp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cgr_pkg::ADDR_W-1:0]  paddr,
    input  logic [cgr_pkg::DATA_W-1:0]  pwdata,
    output logic [cgr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [15:0]                 i_position,
    output logic                        o_done,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    output logic [7:0]                  o_alpha
);
    import cgr_pkg::*;

    logic [2:0]           count;
    t_stop                stop [N_STOPS];
    t_seg                 seg;
    logic [31:0]          dcol_w;
    logic [31:0]          clo_w;
    logic [31:0]          chi_w;
    logic [31:0]          res_w;
    logic [TOTAL_LAT-1:0] r_vld;

    cgr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_count (count),
        .o_stop  (stop)
    );

    cgr_seg u_seg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_position (i_position),
        .i_count    (count),
        .i_stop     (stop),
        .o_seg      (seg)
    );

    assign dcol_w = seg.dcol;
    assign clo_w  = seg.clo;
    assign chi_w  = seg.chi;

    for (genvar c = 0; c < 4; c++) begin : g_chan
        cgr_lerp u_lerp (
            .i_clk    (i_clk),
            .i_direct (seg.direct),
            .i_dcol   (dcol_w[8*(3-c) +: 8]),
            .i_clo    (clo_w[8*(3-c) +: 8]),
            .i_chi    (chi_w[8*(3-c) +: 8]),
            .i_t      (seg.t),
            .i_den    (seg.den),
            .o_chan   (res_w[8*(3-c) +: 8])
        );
    end

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], start && !busy};
        end
    end

    assign o_done  = r_vld[TOTAL_LAT-1];
    assign o_red   = res_w[31:24];
    assign o_green = res_w[23:16];
    assign o_blue  = res_w[15:8];
    assign o_alpha = res_w[7:0];

    `ASSERT_CLK(a_done_follows_request, i_clk, i_rst_n,
        o_done |-> $past(start && !busy, TOTAL_LAT),
        "Result strobe without a request nine cycles earlier.")

endmodule
